// File: rtl/core/epr_pkg.sv
// Shared types, codes and constants for the encoder position read sequencer.
package epr_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_CMD    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NOOP_CMD    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAIT_REPLY  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_POLLS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPACING = 3'd4;
  localparam int CFG_DATA_W = 16;

  // Register reset values
  localparam logic [7:0]  RST_READ_CMD    = 8'h10;
  localparam logic [7:0]  RST_NOOP_CMD    = 8'h00;
  localparam logic [7:0]  RST_WAIT_REPLY  = 8'hA5;
  localparam logic [7:0]  RST_MAX_POLLS   = 8'h10;
  localparam logic [15:0] RST_MIN_SPACING = 16'd20;

  // Request kinds
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_BYTE  = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  // Spacing counter saturates here
  localparam logic [15:0] SPACING_MAX = 16'hFFFF;
  // Position high bits come from the low nibble of the first data reply
  localparam logic [7:0] NIBBLE_MASK = 8'h0F;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SPACING,
    PH_CMD,
    PH_POLL,
    PH_HIGH,
    PH_LOW
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_UNEXPECTED,
    ST_TIMEOUT,
    ST_LINK
  } status_t;

  typedef struct packed {
    logic [7:0]  read_command;
    logic [7:0]  noop_command;
    logic [7:0]  wait_reply;
    logic [7:0]  max_polls;
    logic [15:0] min_spacing_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] rx_byte;
    logic       link_failed;
  } item_t;

  typedef struct packed {
    logic        valid;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        done_res;
    status_t     status;
    logic [11:0] position;
  } result_t;

endpackage

// File: rtl/core/epr_seq.sv
// Read sequencer state machine: state registers and the per-request update.
module epr_seq
  import epr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step_en,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t res
);

  phase_t      phase_r, phase_nxt;
  logic [7:0]  poll_count_r, poll_count_nxt;
  logic [15:0] spacing_r, spacing_nxt;
  logic [3:0]  high_nibble_r, high_nibble_nxt;
  logic [15:0] spacing_inc;
  logic [7:0]  rx_masked;

  assign spacing_inc = (spacing_r == SPACING_MAX) ? spacing_r : spacing_r + 16'd1;
  assign rx_masked   = item.rx_byte & NIBBLE_MASK;

  // Next state
  always_comb begin
    phase_nxt       = phase_r;
    poll_count_nxt  = poll_count_r;
    spacing_nxt     = spacing_r;
    high_nibble_nxt = high_nibble_r;
    case (item.kind)
      KIND_START: begin
        if (phase_r == PH_IDLE) begin
          if (spacing_r >= cfg.min_spacing_ticks) begin
            phase_nxt      = PH_CMD;
            poll_count_nxt = 8'd0;
          end else begin
            phase_nxt = PH_SPACING;
          end
        end
      end
      KIND_TICK: begin
        spacing_nxt = spacing_inc;
        if (phase_r == PH_SPACING && spacing_inc >= cfg.min_spacing_ticks) begin
          phase_nxt      = PH_CMD;
          poll_count_nxt = 8'd0;
        end
      end
      KIND_BYTE: begin
        case (phase_r)
          PH_IDLE, PH_SPACING: begin
          end
          PH_CMD: begin
            if (item.link_failed || cfg.max_polls == 8'd0) begin
              phase_nxt = PH_IDLE;
            end else begin
              phase_nxt      = PH_POLL;
              poll_count_nxt = 8'd1;
            end
          end
          PH_POLL: begin
            if (item.link_failed) begin
              phase_nxt = PH_IDLE;
            end else if (item.rx_byte == cfg.read_command) begin
              phase_nxt = PH_HIGH;
            end else if (item.rx_byte != cfg.wait_reply ||
                         poll_count_r >= cfg.max_polls) begin
              phase_nxt = PH_IDLE;
            end else begin
              poll_count_nxt = poll_count_r + 8'd1;
            end
          end
          PH_HIGH: begin
            if (item.link_failed) begin
              phase_nxt = PH_IDLE;
            end else begin
              high_nibble_nxt = rx_masked[3:0];
              phase_nxt       = PH_LOW;
            end
          end
          PH_LOW: begin
            phase_nxt = PH_IDLE;
            if (!item.link_failed) begin
              spacing_nxt = 16'd0;
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // Result for the current request
  always_comb begin
    res = '0;
    case (item.kind)
      KIND_START: begin
        if (phase_r == PH_IDLE && spacing_r >= cfg.min_spacing_ticks) begin
          res.valid    = 1'b1;
          res.tx_valid = 1'b1;
          res.tx_byte  = cfg.read_command;
        end
      end
      KIND_TICK: begin
        if (phase_r == PH_SPACING && spacing_inc >= cfg.min_spacing_ticks) begin
          res.valid    = 1'b1;
          res.tx_valid = 1'b1;
          res.tx_byte  = cfg.read_command;
        end
      end
      KIND_BYTE: begin
        case (phase_r)
          PH_CMD, PH_POLL, PH_HIGH, PH_LOW: begin
            res.valid = 1'b1;
            if (item.link_failed) begin
              res.done_res = 1'b1;
              res.status   = ST_LINK;
            end else if (phase_r == PH_CMD) begin
              if (cfg.max_polls == 8'd0) begin
                res.done_res = 1'b1;
                res.status   = ST_TIMEOUT;
              end else begin
                res.tx_valid = 1'b1;
                res.tx_byte  = cfg.noop_command;
              end
            end else if (phase_r == PH_POLL) begin
              if (item.rx_byte == cfg.read_command) begin
                res.tx_valid = 1'b1;
                res.tx_byte  = cfg.noop_command;
              end else if (item.rx_byte != cfg.wait_reply) begin
                res.done_res = 1'b1;
                res.status   = ST_UNEXPECTED;
              end else if (poll_count_r >= cfg.max_polls) begin
                res.done_res = 1'b1;
                res.status   = ST_TIMEOUT;
              end else begin
                res.tx_valid = 1'b1;
                res.tx_byte  = cfg.noop_command;
              end
            end else if (phase_r == PH_HIGH) begin
              res.tx_valid = 1'b1;
              res.tx_byte  = cfg.noop_command;
            end else begin
              res.done_res = 1'b1;
              res.status   = ST_OK;
              res.position = {high_nibble_r, item.rx_byte};
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // Commit the update when the request leaves the input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      poll_count_r <= 8'd0;
      spacing_r    <= SPACING_MAX;
    end else if (step_en) begin
      phase_r      <= phase_nxt;
      poll_count_r <= poll_count_nxt;
      spacing_r    <= spacing_nxt;
    end
  end

  // Data nibble holds until the low byte arrives
  always_ff @(posedge clk) begin
    if (step_en) begin
      high_nibble_r <= high_nibble_nxt;
    end
  end

endmodule

// File: rtl/core/encoder_position_read_sequencer.sv
// Top level of the encoder position read sequencer: ports, config and staging.
// Takes one request per clock: start, finished SPI byte exchange or time tick.
// A request is registered on input, handled by the state machine in the
// following cycle and, if it causes a result, lands in the output register,
// so each result passes the input and the output register. The input
// stage keeps moving while the output register can take a new result, so a
// request is accepted every cycle as long as out_tready keeps up; a stalled
// output holds the input stage only for requests that produce a result.
// Each result either names the next byte to send (out_tuser[0]) or ends the
// read with status and position (out_tuser[1]). Write the config registers
// only while no read is in flight.
module encoder_position_read_sequencer
  import epr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Request channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] rx_byte
  input  logic [2:0]            in_tuser,   // [1:0] kind, [2] link_failed
  // Result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [23:0]           out_tdata,  // [7:0] tx_byte, [9:8] status,
                                            // [21:10] position, [23:22] zero
  output logic [1:0]            out_tuser,  // [0] tx_valid, [1] done_res
  // Configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t    cfg_r;
  logic    s1_valid_r, s1_valid_nxt;
  item_t   s1_item_r;
  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r;
  result_t res;
  logic    in_accept;
  logic    out_free;
  logic    s1_adv;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.read_command      <= RST_READ_CMD;
      cfg_r.noop_command      <= RST_NOOP_CMD;
      cfg_r.wait_reply        <= RST_WAIT_REPLY;
      cfg_r.max_polls         <= RST_MAX_POLLS;
      cfg_r.min_spacing_ticks <= RST_MIN_SPACING;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_READ_CMD:    cfg_r.read_command      <= cfg_wdata[7:0];
        CFG_NOOP_CMD:    cfg_r.noop_command      <= cfg_wdata[7:0];
        CFG_WAIT_REPLY:  cfg_r.wait_reply        <= cfg_wdata[7:0];
        CFG_MAX_POLLS:   cfg_r.max_polls         <= cfg_wdata[7:0];
        CFG_MIN_SPACING: cfg_r.min_spacing_ticks <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Handshake: advance the input stage unless its result has nowhere to go
  assign out_free      = !out_valid_r || out_tready;
  assign s1_adv        = s1_valid_r && (!res.valid || out_free);
  assign in_tready     = !s1_valid_r || s1_adv;
  assign in_accept     = in_tvalid && in_tready;
  assign s1_valid_nxt  = in_accept || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = (s1_adv && res.valid) || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r.kind        <= in_tuser[1:0];
      s1_item_r.link_failed <= in_tuser[2];
      s1_item_r.rx_byte     <= in_tdata;
    end
  end

  epr_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (s1_adv),
    .item    (s1_item_r),
    .cfg     (cfg_r),
    .res     (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (s1_adv && res.valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_res_r.position, out_res_r.status, out_res_r.tx_byte};
  assign out_tuser  = {out_res_r.done_res, out_res_r.tx_valid};

endmodule

// File: rtl/core/epr_checker.sv
// Port-level checks for the encoder position read sequencer, bound to the top.
module epr_checker
  import epr_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [23:0]           out_tdata,
  input logic [1:0]            out_tuser
);

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // Each result is either a byte to send or an end of read
  a_kind_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $onehot(out_tuser))
    else $error("result neither send nor done");

  // Send results carry no status or position
  a_send_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[23:8] == 16'd0)
    else $error("send result carries status or position");

  // Failed reads report no position and no byte
  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] && out_tdata[9:8] != ST_OK |->
      out_tdata[21:10] == 12'd0 && out_tdata[7:0] == 8'd0)
    else $error("failed read carries data");

endmodule

bind encoder_position_read_sequencer epr_checker u_epr_checker (.*);

// File: test/testbench.sv
// Self-checking testbench for the encoder position read sequencer.
`timescale 1ns / 1ps

module testbench;
  import epr_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 2;
  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int RANDOM_ITEMS   = 420;
  localparam int TIMEOUT_CYCLES = 1_500_000;

  // Kind code the block does not use
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // One expected output of the sequencer
  typedef struct {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        done;
    status_t     status;
    logic [11:0] position;
  } seq_out_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;   // [7:0] rx_byte
  logic [2:0]  in_tuser   = '0;   // [1:0] kind, [2] link_failed
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;         // [7:0] tx_byte, [9:8] status, [21:10] position
  logic [1:0]  out_tuser;         // [0] tx_valid, [1] done_res
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Predicted sequencer state and register copy
  cfg_t        cfg_shadow;
  phase_t      rd_phase;
  logic [7:0]  polls_done;
  logic [15:0] ticks_since_read;
  logic [3:0]  pos_high;

  seq_out_t read_outputs_due[$];
  seq_out_t head_due;
  int       error_count  = 0;
  int       acted_items  = 0;
  logic     sender_idles   = 1'b0;
  logic     receiver_idles = 1'b0;
  logic     holdoff_req    = 1'b0;

  encoder_position_read_sequencer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Mostly short gaps, now and then a long one
  function automatic int idle_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  task automatic push_tx(input logic [7:0] b);
    seq_out_t e;
    e.tx_valid = 1'b1;
    e.tx_byte  = b;
    e.done     = 1'b0;
    e.status   = ST_OK;
    e.position = '0;
    read_outputs_due.push_back(e);
  endtask

  // Close the read and return to idle
  task automatic push_done(input status_t st, input logic [11:0] pos);
    seq_out_t e;
    e.tx_valid = 1'b0;
    e.tx_byte  = '0;
    e.done     = 1'b1;
    e.status   = st;
    e.position = pos;
    read_outputs_due.push_back(e);
    rd_phase = PH_IDLE;
  endtask

  task automatic issue_command();
    rd_phase   = PH_CMD;
    polls_done = '0;
    push_tx(cfg_shadow.read_command);
  endtask

  // Advance the predicted sequencer by one accepted request
  task automatic predict_read_step(input logic [1:0] kind, input logic [7:0] rx,
                                   input logic fail);
    case (kind)
      KIND_START: begin
        if (rd_phase == PH_IDLE) begin
          acted_items++;
          if (ticks_since_read >= cfg_shadow.min_spacing_ticks) issue_command();
          else rd_phase = PH_SPACING;
        end
      end
      KIND_TICK: begin
        acted_items++;
        if (ticks_since_read != SPACING_MAX) ticks_since_read = ticks_since_read + 16'd1;
        if (rd_phase == PH_SPACING && ticks_since_read >= cfg_shadow.min_spacing_ticks)
          issue_command();
      end
      KIND_BYTE: begin
        if (rd_phase != PH_IDLE && rd_phase != PH_SPACING) begin
          acted_items++;
          if (fail) begin
            push_done(ST_LINK, '0);
          end else begin
            case (rd_phase)
              PH_CMD: begin
                if (cfg_shadow.max_polls == 8'd0) begin
                  push_done(ST_TIMEOUT, '0);
                end else begin
                  rd_phase   = PH_POLL;
                  polls_done = 8'd1;
                  push_tx(cfg_shadow.noop_command);
                end
              end
              PH_POLL: begin
                // the echo wins over the wait code when both match
                if (rx == cfg_shadow.read_command) begin
                  rd_phase = PH_HIGH;
                  push_tx(cfg_shadow.noop_command);
                end else if (rx != cfg_shadow.wait_reply) begin
                  push_done(ST_UNEXPECTED, '0);
                end else if (polls_done >= cfg_shadow.max_polls) begin
                  push_done(ST_TIMEOUT, '0);
                end else begin
                  polls_done = polls_done + 8'd1;
                  push_tx(cfg_shadow.noop_command);
                end
              end
              PH_HIGH: begin
                pos_high = 4'(rx & NIBBLE_MASK);
                rd_phase = PH_LOW;
                push_tx(cfg_shadow.noop_command);
              end
              PH_LOW: begin
                ticks_since_read = '0;
                push_done(ST_OK, {pos_high, rx});
              end
              default: rd_phase = PH_IDLE;
            endcase
          end
        end
      end
      default: ;
    endcase
  endtask

  // Offer one request, wait for the handshake, then predict its outputs
  task automatic send_request(input logic [1:0] kind, input logic [7:0] rx, input logic fail);
    int gap;
    gap = (sender_idles && $urandom_range(0, 2) == 0) ? idle_len() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= rx;
    in_tuser  <= {fail, kind};
    do @(posedge clk); while (!in_tready);
    predict_read_step(kind, rx, fail);
  endtask

  // Drop the request line, wait for all outputs, then let the pipeline empty
  task automatic wait_until_drained();
    in_tvalid <= 1'b0;
    while (read_outputs_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all five registers back to back; call only while idle
  task automatic load_settings(input logic [7:0] rcmd, input logic [7:0] noop,
                               input logic [7:0] waitb, input logic [7:0] polls,
                               input logic [15:0] spacing);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_READ_CMD;
    cfg_wdata <= {8'h00, rcmd};
    @(posedge clk);
    cfg_index <= CFG_NOOP_CMD;
    cfg_wdata <= {8'h00, noop};
    @(posedge clk);
    cfg_index <= CFG_WAIT_REPLY;
    cfg_wdata <= {8'h00, waitb};
    @(posedge clk);
    cfg_index <= CFG_MAX_POLLS;
    cfg_wdata <= {8'h00, polls};
    @(posedge clk);
    cfg_index <= CFG_MIN_SPACING;
    cfg_wdata <= spacing;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_shadow.read_command      = rcmd;
    cfg_shadow.noop_command      = noop;
    cfg_shadow.wait_reply        = waitb;
    cfg_shadow.max_polls         = polls;
    cfg_shadow.min_spacing_ticks = spacing;
  endtask

  // Start one read and answer it until it ends; noise requests are mixed in
  task automatic run_read(input int wait_polls, input int fault_pct, input int noise_pct);
    int         waits_sent;
    int         pick;
    logic [7:0] b;
    waits_sent = 0;
    send_request(KIND_START, 8'($urandom), 1'($urandom));
    while (rd_phase != PH_IDLE) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        pick = $urandom_range(0, 2);
        send_request(pick == 0 ? KIND_START : (pick == 1 ? KIND_TICK : KIND_UNUSED),
                     8'($urandom), 1'($urandom));
      end else begin
        case (rd_phase)
          PH_SPACING: send_request(KIND_TICK, 8'($urandom), 1'($urandom));
          PH_POLL: begin
            if ($urandom_range(0, 99) < fault_pct) begin
              b = 8'($urandom);
            end else if (waits_sent < wait_polls) begin
              b = cfg_shadow.wait_reply;
              waits_sent++;
            end else begin
              b = cfg_shadow.read_command;
            end
            send_request(KIND_BYTE, b, $urandom_range(0, 99) < fault_pct);
          end
          default: send_request(KIND_BYTE, 8'($urandom), $urandom_range(0, 99) < fault_pct);
        endcase
      end
    end
  endtask

  // Full read on reset settings, ignored requests, spacing hold after a good read
  task automatic test_reset_defaults();
    // saturated spacing counter holds across ticks, so the start goes straight out
    repeat (4) send_request(KIND_TICK, 8'h00, 1'b0);
    send_request(KIND_BYTE, 8'h10, 1'b1);
    send_request(KIND_UNUSED, 8'hFF, 1'b1);
    send_request(KIND_START, 8'h00, 1'b0);
    send_request(KIND_BYTE, 8'h00, 1'b0);
    send_request(KIND_START, 8'hFF, 1'b0);
    send_request(KIND_BYTE, 8'hA5, 1'b0);
    send_request(KIND_BYTE, 8'hA5, 1'b0);
    send_request(KIND_BYTE, 8'h10, 1'b0);
    send_request(KIND_BYTE, 8'hFF, 1'b0);
    send_request(KIND_BYTE, 8'hFF, 1'b0);
    send_request(KIND_START, 8'h00, 1'b0);
    send_request(KIND_BYTE, 8'h55, 1'b0);
    while (rd_phase == PH_SPACING) send_request(KIND_TICK, 8'h00, 1'b0);
    send_request(KIND_BYTE, 8'hEE, 1'b0);
    send_request(KIND_BYTE, 8'h10, 1'b0);
    send_request(KIND_BYTE, 8'hF0, 1'b0);
    send_request(KIND_BYTE, 8'h00, 1'b0);
  endtask

  // Link failure in each busy phase, unexpected reply, timeouts, echo over wait code
  task automatic test_error_endings();
    wait_until_drained();
    load_settings(8'hFF, 8'hFF, 8'h00, 8'd1, 16'd0);
    send_request(KIND_START, 8'h00, 1'b0);
    send_request(KIND_BYTE, 8'h00, 1'b1);
    send_request(KIND_START, 8'h00, 1'b0);
    send_request(KIND_BYTE, 8'h3C, 1'b0);
    send_request(KIND_BYTE, 8'h00, 1'b1);
    send_request(KIND_START, 8'h00, 1'b0);
    send_request(KIND_BYTE, 8'h00, 1'b0);
    send_request(KIND_BYTE, 8'hFF, 1'b0);
    send_request(KIND_BYTE, 8'h12, 1'b1);
    send_request(KIND_START, 8'h00, 1'b0);
    send_request(KIND_BYTE, 8'h00, 1'b0);
    send_request(KIND_BYTE, 8'hFF, 1'b0);
    send_request(KIND_BYTE, 8'hAB, 1'b0);
    send_request(KIND_BYTE, 8'hCD, 1'b1);
    send_request(KIND_START, 8'h00, 1'b0);
    send_request(KIND_BYTE, 8'h00, 1'b0);
    send_request(KIND_BYTE, 8'h00, 1'b0);
    send_request(KIND_START, 8'h00, 1'b0);
    send_request(KIND_BYTE, 8'h00, 1'b0);
    send_request(KIND_BYTE, 8'h3C, 1'b0);
    // zero poll limit: timeout right after the command exchange
    wait_until_drained();
    load_settings(8'h5A, 8'h81, 8'h5A, 8'd0, 16'd0);
    send_request(KIND_START, 8'h00, 1'b0);
    send_request(KIND_BYTE, 8'h77, 1'b0);
    wait_until_drained();
    load_settings(8'h5A, 8'h81, 8'h5A, 8'd255, 16'd0);
    send_request(KIND_START, 8'h00, 1'b0);
    send_request(KIND_BYTE, 8'h00, 1'b0);
    send_request(KIND_BYTE, 8'h5A, 1'b0);
    send_request(KIND_BYTE, 8'h0A, 1'b0);
    send_request(KIND_BYTE, 8'h5A, 1'b0);
  endtask

  // Long spacing hold, link failure keeps the spacing, smallest nonzero spacing
  task automatic test_spacing_limits();
    wait_until_drained();
    load_settings(RST_READ_CMD, RST_NOOP_CMD, RST_WAIT_REPLY, 8'd255, 16'd100);
    send_request(KIND_START, 8'h00, 1'b0);
    while (rd_phase == PH_SPACING) send_request(KIND_TICK, 8'($urandom), 1'($urandom));
    repeat (4) send_request(KIND_TICK, 8'($urandom), 1'($urandom));
    send_request(KIND_BYTE, 8'h00, 1'b1);
    // no good read since, so the next start goes straight out
    run_read(1, 0, 0);
    wait_until_drained();
    load_settings(RST_READ_CMD, RST_NOOP_CMD, RST_WAIT_REPLY, 8'd3, 16'd1);
    run_read(0, 0, 0);
    run_read(2, 0, 0);
  endtask

  // Hold off results while requests keep coming so the input stalls
  task automatic test_result_backpressure();
    wait_until_drained();
    load_settings(8'h10, 8'h00, 8'hA5, 8'd4, 16'd0);
    holdoff_req = 1'b1;
    repeat (3) run_read(2, 0, 0);
  endtask

  // Random settings per phase, mostly well-formed reads with random content
  task automatic test_random_reads();
    int         target;
    int         phase_end;
    int         wait_polls;
    logic [7:0] rcmd;
    target = acted_items + RANDOM_ITEMS;
    while (acted_items < target) begin
      wait_until_drained();
      rcmd = 8'($urandom);
      load_settings(rcmd, 8'($urandom),
                    ($urandom_range(0, 7) == 0) ? rcmd : 8'($urandom),
                    ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                : 8'($urandom_range(1, 6)),
                    ($urandom_range(0, 4) == 0) ? 16'($urandom_range(11, 60))
                                                : 16'($urandom_range(0, 10)));
      sender_idles   = ($urandom_range(0, 3) != 0);
      receiver_idles = ($urandom_range(0, 3) != 0);
      phase_end = acted_items + $urandom_range(40, 90);
      while (acted_items < phase_end) begin
        if ($urandom_range(0, 6) == 0)
          send_request(2'($urandom_range(1, 3)), 8'($urandom), 1'($urandom));
        wait_polls = ($urandom_range(0, 4) == 0) ? int'(cfg_shadow.max_polls)
                                                 : $urandom_range(0, 3);
        run_read(wait_polls, ($urandom_range(0, 1) == 0) ? 0 : 6, 8);
      end
    end
  endtask

  // Drive the result side: long hold-off on demand, random stalls otherwise
  initial begin
    forever begin
      @(posedge clk);
      if (holdoff_req) begin
        holdoff_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
      end else if (receiver_idles && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat (idle_len()) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Compare each accepted result with the oldest pending expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (read_outputs_due.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: user %b data %h",
                                  out_tuser, out_tdata));
      end else begin
        head_due = read_outputs_due.pop_front();
        if (out_tuser[0] !== head_due.tx_valid || out_tdata[7:0] !== head_due.tx_byte ||
            out_tuser[1] !== head_due.done || out_tdata[9:8] !== head_due.status ||
            out_tdata[21:10] !== head_due.position)
          report_mismatch($sformatf(
            "tx %b/%h done %b st %0d pos %h, wanted tx %b/%h done %b st %0d pos %h",
            out_tuser[0], out_tdata[7:0], out_tuser[1], out_tdata[9:8], out_tdata[21:10],
            head_due.tx_valid, head_due.tx_byte, head_due.done, head_due.status,
            head_due.position));
      end
    end
  end

  // Hard stop for a hung run
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Verification failed");
    $finish;
  end

  initial begin
    cfg_shadow.read_command      = RST_READ_CMD;
    cfg_shadow.noop_command      = RST_NOOP_CMD;
    cfg_shadow.wait_reply        = RST_WAIT_REPLY;
    cfg_shadow.max_polls         = RST_MAX_POLLS;
    cfg_shadow.min_spacing_ticks = RST_MIN_SPACING;
    rd_phase         = PH_IDLE;
    polls_done       = '0;
    ticks_since_read = SPACING_MAX;
    pos_high         = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_error_endings();
    test_spacing_limits();
    test_result_backpressure();
    test_random_reads();
    wait_until_drained();
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
